// ===== sv/alad_pkg.sv =====
// ----------------------------------------------------------------------------
// alad_pkg: shared types for the array list append/delete unit
// Operation and status codes, controller states and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package alad_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 64;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PASS = 2'd1,
    S_RESP = 2'd2
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // every cell takes its upper neighbor's entry; the last cell keeps its own
    logic push;   // the tail cell takes the head entry instead
    logic load;   // the addressed cell takes the appended value
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/alad_cell.sv =====
// ----------------------------------------------------------------------------
// alad_cell: one storage cell of the list chain
// Holds one entry; shifts down from its neighbor, takes the recirculated
// head when it is the tail of the loop, or loads an appended value.
// ----------------------------------------------------------------------------
`default_nettype none

module alad_cell
  import alad_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int unsigned IW         = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [IW-1:0]         tail_idx,
  input  logic [IW-1:0]         load_idx,
  input  logic [DATA_WIDTH-1:0] load_val,
  input  logic [DATA_WIDTH-1:0] head_val,
  input  logic [DATA_WIDTH-1:0] next_val,
  output logic [DATA_WIDTH-1:0] entry_q
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.load && (load_idx == MY_IDX)) begin
      entry_q <= load_val;
    end else if (ctrl.shift) begin
      if (ctrl.push && (tail_idx == MY_IDX)) begin
        entry_q <= head_val;
      end else begin
        entry_q <= next_val;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/array_list_append_delete_unit.sv =====
// ----------------------------------------------------------------------------
// array_list_append_delete_unit: fixed-capacity contiguous list
// Entries live in a chain of cells. Delete and dump rotate the held part of
// the chain through the head cell, dropping the first match on delete.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  op, value
//   out      source     out_valid/out_stall  status, entry, last, count
//
// Append and the unused op are accepted, then their result goes out.
// Delete rotates used places, then gives its result; dump gives used results,
// one per cycle while out_stall allows. Rotation moves one place a cycle.
// Reset empties the list; entries themselves are not cleared.
// Items are taken one at a time; out_stall holds the rotation during a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_append_delete_unit
  import alad_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  last,
  output logic [CW-1:0]         count
);

  state_t                state, state_next;
  op_t                   op_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [CW-1:0]         used, used_next;
  logic [CW-1:0]         step, step_next;
  logic [IW-1:0]         tail, tail_next;
  logic                  found, found_next;
  status_t               res, res_next;

  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] next_q [DEPTH];
  logic [DATA_WIDTH-1:0] head;

  logic                  in_xfer;
  logic                  out_free;
  logic                  out_load;
  status_t               o_status;
  logic [DATA_WIDTH-1:0] o_entry;
  logic                  o_last;
  logic [CW-1:0]         used_m1;
  logic                  step_last;
  logic                  match;

  assign head      = cell_q[0];
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign used_m1   = used - CW'(1);
  assign step_last = ((step + CW'(1)) == used);
  assign match     = !found && (head == value_q);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_end
      assign next_q[i] = cell_q[i];
    end else begin : g_mid
      assign next_q[i] = cell_q[i+1];
    end
    alad_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .tail_idx (tail),
      .load_idx (used[IW-1:0]),
      .load_val (value),
      .head_val (head),
      .next_val (next_q[i]),
      .entry_q  (cell_q[i])
    );
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    step_next  = step;
    tail_next  = tail;
    found_next = found;
    res_next   = res;
    ctrl       = '0;
    out_load   = 1'b0;
    o_status   = ST_OK;
    o_entry    = '0;
    o_last     = 1'b1;
    case (state)
      S_IDLE: begin
        step_next  = '0;
        tail_next  = used_m1[IW-1:0];
        found_next = 1'b0;
        if (in_valid) begin
          state_next = S_RESP;
          res_next   = ST_OK;
          case (op_t'(op))
            OP_APPEND: begin
              if (used == CW'(DEPTH)) begin
                res_next = ST_FULL;
              end else begin
                ctrl.load = 1'b1;
                used_next = used + CW'(1);
              end
            end
            OP_DELETE: begin
              if (used == '0) begin
                res_next = ST_NOT_FOUND;
              end else begin
                state_next = S_PASS;
              end
            end
            OP_DUMP: begin
              if (used == '0) begin
                res_next = ST_EMPTY;
              end else begin
                state_next = S_PASS;
              end
            end
            default: res_next = ST_OK;
          endcase
        end
      end
      S_PASS: begin
        if (op_q == OP_DUMP) begin
          // The head entry goes out and recirculates to the tail.
          if (out_free) begin
            out_load   = 1'b1;
            o_entry    = head;
            o_last     = step_last;
            ctrl.shift = 1'b1;
            ctrl.push  = 1'b1;
            step_next  = step + CW'(1);
            if (step_last) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          // The first match is dropped; the loop gets one place shorter.
          ctrl.shift = 1'b1;
          ctrl.push  = !match;
          step_next  = step + CW'(1);
          if (match) begin
            found_next = 1'b1;
            tail_next  = tail - IW'(1);
          end
          if (step_last) begin
            state_next = S_RESP;
            if (found || match) begin
              res_next  = ST_OK;
              used_next = used_m1;
            end else begin
              res_next = ST_NOT_FOUND;
            end
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_status   = res;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      found <= found_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
    tail <= tail_next;
    res  <= res_next;
    if (in_xfer) begin
      op_q    <= op_t'(op);
      value_q <= value;
    end
    if (out_load) begin
      status <= o_status;
      entry  <= o_entry;
      last   <= o_last;
      count  <= used_next;
    end
  end

  a_used_range : assert property (@(posedge clk) disable iff (rst)
    used <= CW'(DEPTH))
    else $error("list count above capacity");

  a_pass_nonempty : assert property (@(posedge clk) disable iff (rst)
    state == S_PASS |-> (used != '0) && (step < used))
    else $error("rotation pass on an empty list or past its end");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("pending result overwritten");

  a_delete_shrinks : assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS) && (op_q == OP_DELETE) && step_last && (found || match)
    |=> used == $past(used) - CW'(1))
    else $error("delete with a match did not shrink the list");

endmodule

`default_nettype wire
